// ===== rtl/core/hsl_pkg.sv =====
// Package for the HSL to RGB converter: widths, constants, stage types and helpers.
package hsl_pkg;

	localparam int FRACTION_BITS = 10;
	localparam int REG_W         = 11;
	localparam int HUE_W         = 9;
	localparam int CH_W          = 8;
	localparam int CFG_IDX_W     = 2;

	// Clamped saturation / lightness: 0 .. 1 << FRACTION_BITS
	localparam int FX_W   = FRACTION_BITS + 1;
	localparam int CMP_W  = (REG_W > FX_W) ? REG_W : FX_W;
	// Lightness times 120
	localparam int BASE_W = FX_W + 7;
	// a * s, at most 1 << (2 * FRACTION_BITS)
	localparam int P_W    = 2 * FRACTION_BITS + 1;
	// Signed channel weight in -60 .. 60
	localparam int COEF_W = 7;
	localparam int PROD_W = P_W + 1 + COEF_W;
	localparam int SUM_W  = 2 * FRACTION_BITS + 12;
	// 255 / (120 * F * F) = 17 / 2^(2 * FRACTION_BITS + 3)
	localparam int SHIFT  = 2 * FRACTION_BITS + 3;
	localparam int NUM_CH = 3;

	localparam logic [CMP_W-1:0] ONE_FX = CMP_W'(1) << FRACTION_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_SATURATION = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LIGHTNESS  = CFG_IDX_W'(1);

	localparam logic [REG_W-1:0] SATURATION_RESET = REG_W'(1014);
	localparam logic [REG_W-1:0] LIGHTNESS_RESET  = REG_W'(512);

	localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(359);

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	typedef struct packed {
		logic [NUM_CH-1:0][COEF_W-1:0] coef;
		logic [FX_W-1:0]               a;
		logic [FX_W-1:0]               s;
		logic [BASE_W-1:0]             base;
	} s1_t;

	typedef struct packed {
		logic [NUM_CH-1:0][COEF_W-1:0] coef;
		logic [P_W-1:0]                p;
		logic [BASE_W-1:0]             base;
	} s2_t;

	typedef struct packed {
		logic [NUM_CH-1:0][PROD_W-1:0] prod;
		logic [BASE_W-1:0]             base;
	} s3_t;

	function automatic logic [FX_W-1:0] clamp_one(input logic [REG_W-1:0] v);
		logic [CMP_W-1:0] w;
		w = CMP_W'(v);
		if (w > ONE_FX) begin
			return FX_W'(ONE_FX);
		end
		return FX_W'(w);
	endfunction

endpackage

// ===== rtl/core/hsl_if.sv =====
// Stream interfaces for the hue input and the RGB result channel.
interface hsl_hue_if;
	logic                      valid;
	logic                      ready;
	logic [hsl_pkg::HUE_W-1:0] hue_degrees;

	modport source(output valid, output hue_degrees, input ready);
	modport sink(input valid, input hue_degrees, output ready);
endinterface

interface hsl_rgb_if;
	logic                     valid;
	logic                     ready;
	logic [hsl_pkg::CH_W-1:0] red;
	logic [hsl_pkg::CH_W-1:0] green;
	logic [hsl_pkg::CH_W-1:0] blue;

	modport source(output valid, output red, output green, output blue, input ready);
	modport sink(input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/core/hsl_sector.sv =====
// Stage 1: hue clamp, sector decode, channel weights and lightness terms.
module hsl_sector (
	input  logic                        clk,
	input  logic                        en,
	input  logic [hsl_pkg::HUE_W-1:0]   hue,
	input  logic [hsl_pkg::REG_W-1:0]   saturation,
	input  logic [hsl_pkg::REG_W-1:0]   lightness,
	output hsl_pkg::s1_t                s1
);

	logic [hsl_pkg::HUE_W-1:0]  h;
	logic [hsl_pkg::HUE_W-1:0]  t;
	logic [5:0]                 tri_w;
	logic [hsl_pkg::COEF_W-1:0] coef_c;
	logic [hsl_pkg::COEF_W-1:0] coef_x;
	logic [hsl_pkg::COEF_W-1:0] coef_z;
	logic [hsl_pkg::FX_W-1:0]   l;
	logic [hsl_pkg::FX_W:0]     twol;
	logic [hsl_pkg::FX_W:0]     one_w;
	logic [hsl_pkg::FX_W:0]     l_dev;
	hsl_pkg::s1_t               nxt;

	always_comb begin
		h = (hue > hsl_pkg::HUE_MAX) ? hsl_pkg::HUE_MAX : hue;
		// fold h mod 120 into a triangle 0..60
		if (h >= hsl_pkg::HUE_W'(240)) begin
			t = h - hsl_pkg::HUE_W'(240);
		end else if (h >= hsl_pkg::HUE_W'(120)) begin
			t = h - hsl_pkg::HUE_W'(120);
		end else begin
			t = h;
		end
		tri_w = (t >= hsl_pkg::HUE_W'(60)) ? 6'(hsl_pkg::HUE_W'(120) - t) : 6'(t);

		// weight 2k - 60: chroma k = 60, secondary k = tri, zero k = 0
		coef_c = hsl_pkg::COEF_W'(60);
		coef_x = hsl_pkg::COEF_W'({tri_w, 1'b0}) - hsl_pkg::COEF_W'(60);
		coef_z = -hsl_pkg::COEF_W'(60);

		if (h < hsl_pkg::HUE_W'(60)) begin
			nxt.coef = {coef_z, coef_x, coef_c};
		end else if (h < hsl_pkg::HUE_W'(120)) begin
			nxt.coef = {coef_z, coef_c, coef_x};
		end else if (h < hsl_pkg::HUE_W'(180)) begin
			nxt.coef = {coef_x, coef_c, coef_z};
		end else if (h < hsl_pkg::HUE_W'(240)) begin
			nxt.coef = {coef_c, coef_x, coef_z};
		end else if (h < hsl_pkg::HUE_W'(300)) begin
			nxt.coef = {coef_c, coef_z, coef_x};
		end else begin
			nxt.coef = {coef_x, coef_z, coef_c};
		end

		// a = 1 - |2L - 1|
		l     = hsl_pkg::clamp_one(lightness);
		twol  = {l, 1'b0};
		one_w = (hsl_pkg::FX_W + 1)'(hsl_pkg::ONE_FX);
		l_dev = (twol >= one_w) ? (twol - one_w) : (one_w - twol);
		nxt.a = hsl_pkg::FX_W'(one_w - l_dev);
		nxt.s = hsl_pkg::clamp_one(saturation);
		nxt.base = hsl_pkg::BASE_W'(l) * hsl_pkg::BASE_W'(120);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1 <= nxt;
		end
	end

endmodule

// ===== rtl/core/hsl_mult.sv =====
// Stages 2 and 3: chroma product a*s, then the signed per-channel weighting.
module hsl_mult (
	input  logic               clk,
	input  hsl_pkg::stage_en_t en,
	input  hsl_pkg::s1_t       s1,
	output hsl_pkg::s3_t       s3
);

	hsl_pkg::s2_t s2;
	hsl_pkg::s3_t nxt3;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			s2.coef <= s1.coef;
			s2.base <= s1.base;
			s2.p    <= hsl_pkg::P_W'(s1.a) * hsl_pkg::P_W'(s1.s);
		end
	end

	always_comb begin
		nxt3.base = s2.base;
		for (int i = 0; i < hsl_pkg::NUM_CH; i++) begin
			nxt3.prod[i] = hsl_pkg::PROD_W'($signed({1'b0, s2.p}))
			             * hsl_pkg::PROD_W'($signed(s2.coef[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			s3 <= nxt3;
		end
	end

endmodule

// ===== rtl/core/hsl_mix.sv =====
// Stage 4: add the lightness term, scale by 255 and truncate to 8-bit channels.
module hsl_mix (
	input  logic                     clk,
	input  logic                     en,
	input  hsl_pkg::s3_t             s3,
	output logic [hsl_pkg::CH_W-1:0] red_s4,
	output logic [hsl_pkg::CH_W-1:0] green_s4,
	output logic [hsl_pkg::CH_W-1:0] blue_s4
);

	logic signed [hsl_pkg::SUM_W-1:0] sum    [hsl_pkg::NUM_CH];
	logic signed [hsl_pkg::SUM_W-1:0] scaled [hsl_pkg::NUM_CH];
	logic        [hsl_pkg::CH_W-1:0]  ch     [hsl_pkg::NUM_CH];

	always_comb begin
		for (int i = 0; i < hsl_pkg::NUM_CH; i++) begin
			sum[i] = hsl_pkg::SUM_W'($signed({1'b0, s3.base, {hsl_pkg::FRACTION_BITS{1'b0}}}))
			       + hsl_pkg::SUM_W'($signed(s3.prod[i]));
			// times 17, then divide by 2^SHIFT
			scaled[i] = (sum[i] <<< 4) + sum[i];
			ch[i]     = scaled[i][hsl_pkg::SHIFT +: hsl_pkg::CH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s4   <= ch[hsl_pkg::CH_RED];
			green_s4 <= ch[hsl_pkg::CH_GREEN];
			blue_s4  <= ch[hsl_pkg::CH_BLUE];
		end
	end

endmodule

// ===== rtl/core/hsl_to_rgb_converter_top.sv =====
// Top level of the HSL to RGB converter: config registers, pipeline control, datapath.
// Each hue's RGB result passes the s1, s2, s3 and s4 registers before it is valid.
// Throughput: one hue per cycle unless the output stalls; the four register stages
// (decode, a*s multiply, weight multiply, sum and scale) each advance when free.
// Reset: arst_n clears all stage valid bits and loads saturation 1014, lightness 512.
module hsl_to_rgb_converter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hsl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hsl_pkg::REG_W-1:0]     cfg_data,
	hsl_hue_if.sink                       hue_in,
	hsl_rgb_if.source                     rgb_out
);

	logic [hsl_pkg::REG_W-1:0] saturation_q;
	logic [hsl_pkg::REG_W-1:0] lightness_q;

	// one valid bit per stage, traveling with the data
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;

	hsl_pkg::stage_en_t en;
	hsl_pkg::s1_t       s1;
	hsl_pkg::s3_t       s3;

	// Configuration: writes to unknown indexes drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saturation_q <= hsl_pkg::SATURATION_RESET;
			lightness_q  <= hsl_pkg::LIGHTNESS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				hsl_pkg::REG_SATURATION: saturation_q <= cfg_data;
				hsl_pkg::REG_LIGHTNESS:  lightness_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage advances when it is empty or the stage after it advances, so
	// bubbles collapse and a stall at the output holds every full stage with no bubble after it.
	always_comb begin
		en.s4 = !valid_s4 || rgb_out.ready;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign hue_in.ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) begin
				valid_s1 <= hue_in.valid;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.s3) begin
				valid_s3 <= valid_s2;
			end
			if (en.s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Stage 1: hue decode and lightness-derived terms
	hsl_sector u_sector (
		.clk        (clk),
		.en         (en.s1),
		.hue        (hue_in.hue_degrees),
		.saturation (saturation_q),
		.lightness  (lightness_q),
		.s1         (s1)
	);

	// Stages 2 and 3: the two multiplies
	hsl_mult u_mult (
		.clk (clk),
		.en  (en),
		.s1  (s1),
		.s3  (s3)
	);

	// Stage 4: final sum and scale, held here until the output transfer
	hsl_mix u_mix (
		.clk      (clk),
		.en       (en.s4),
		.s3       (s3),
		.red_s4   (rgb_out.red),
		.green_s4 (rgb_out.green),
		.blue_s4  (rgb_out.blue)
	);

	assign rgb_out.valid = valid_s4;

endmodule
